/* hw/rtl/teq_pkg.sv */
// ----------------------------------------------------------------------------
// teq_pkg
// Types, codes and helpers shared by the timed event queue modules.
// ----------------------------------------------------------------------------
package teq_pkg;

   localparam int ELEM_W   = 6;
   localparam int TIME_W   = 64;
   localparam int TYPE_W   = 3;
   localparam int STAT_W   = 3;
   localparam int ID_RANGE = 2 ** ELEM_W;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 64;

   localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_CANCEL = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_FRAME  = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_POP    = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_CLEAR  = 3'd4;

   localparam logic [STAT_W-1:0] STAT_DONE        = 3'd0;
   localparam logic [STAT_W-1:0] STAT_DISABLED    = 3'd1;
   localparam logic [STAT_W-1:0] STAT_PENDING     = 3'd2;
   localparam logic [STAT_W-1:0] STAT_NOT_PENDING = 3'd3;
   localparam logic [STAT_W-1:0] STAT_NONE_DUE    = 3'd4;

   localparam logic [TIME_W-1:0] FRAME_SPAN_RESET = 64'd50000000000;
   localparam logic [TIME_W-1:0] SIM_TIME_RESET   = 64'd1;

   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic [ELEM_W-1:0] element_id;
      logic [TIME_W-1:0] delay;
   } teq_req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ELEM_W-1:0] popped_element;
      logic [TIME_W-1:0] event_time;
      logic [TIME_W-1:0] current_time;
   } teq_rsp_type;

   typedef struct packed {
      logic              accept_events;
      logic [TIME_W-1:0] frame_span;
   } teq_csr_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_SHIFT,
      CELL_CLEAR
   } teq_cell_op_type;

   typedef struct packed {
      teq_cell_op_type   op;
      logic [ELEM_W-1:0] id;
      logic [TIME_W-1:0] stamp;
   } teq_cell_ctrl_type;

   typedef struct packed {
      logic              valid;
      logic [ELEM_W-1:0] id;
      logic [TIME_W-1:0] stamp;
   } teq_entry_type;

   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
   endfunction

endpackage

/* hw/rtl/teq_csr.sv */
// ----------------------------------------------------------------------------
// teq_csr
// APB register file: accept_events at byte 0, frame_span at byte 8.
// ----------------------------------------------------------------------------
module teq_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [teq_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [teq_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [teq_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready,
   output teq_pkg::teq_csr_type        csr_regs
);
   import teq_pkg::*;

   logic              accept_ff, accept_in;
   logic [TIME_W-1:0] span_ff, span_in;
   logic              wr_en;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      accept_in = accept_ff;
      span_in   = span_ff;
      if (wr_en) begin
         if (csr_paddr[3]) begin
            span_in = csr_pwdata;
         end else begin
            accept_in = csr_pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accept_ff <= 1'b0;
         span_ff   <= FRAME_SPAN_RESET;
      end else begin
         accept_ff <= accept_in;
         span_ff   <= span_in;
      end
   end

   always_comb begin
      if (csr_paddr[2:0] != 3'd0) begin
         csr_prdata = '0;
      end else if (csr_paddr[3]) begin
         csr_prdata = span_ff;
      end else begin
         csr_prdata = {{(DATA_W-1){1'b0}}, accept_ff};
      end
   end

   assign csr_regs.accept_events = accept_ff;
   assign csr_regs.frame_span    = span_ff;

endmodule

/* hw/rtl/teq_cell.sv */
// ----------------------------------------------------------------------------
// teq_cell
// One slot of the sorted queue. Holds an element and its event time and
// moves data to or from its neighbors on insert, cancel and pop.
// ----------------------------------------------------------------------------
module teq_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  teq_pkg::teq_cell_ctrl_type  ctrl,
   input  teq_pkg::teq_entry_type      left_entry,
   input  logic                        left_keep,
   input  teq_pkg::teq_entry_type      right_entry,
   input  logic                        hit_in,
   output teq_pkg::teq_entry_type      entry,
   output logic                        keep,
   output logic                        hit_out
);
   import teq_pkg::*;

   teq_entry_type ent_ff, ent_in;

   // keep: this slot stays ahead of the new event
   assign keep    = ent_ff.valid && (ent_ff.stamp < ctrl.stamp);
   assign hit_out = hit_in || (ent_ff.valid && (ent_ff.id == ctrl.id));

   always_comb begin
      ent_in = ent_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (!keep) begin
               if (left_keep) begin
                  ent_in.valid = 1'b1;
                  ent_in.id    = ctrl.id;
                  ent_in.stamp = ctrl.stamp;
               end else begin
                  ent_in = left_entry;
               end
            end
         end
         CELL_REMOVE: begin
            if (hit_out) begin
               ent_in = right_entry;
            end
         end
         CELL_SHIFT: begin
            ent_in = right_entry;
         end
         CELL_CLEAR: begin
            ent_in.valid = 1'b0;
         end
         default: begin
            ent_in = ent_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff <= '0;
      end else begin
         ent_ff <= ent_in;
      end
   end

   assign entry = ent_ff;

endmodule

/* hw/rtl/timed_event_queue_unit.sv */
// ----------------------------------------------------------------------------
// timed_event_queue_unit
// Time-ordered event queue built as a row of sorted cells.
// ----------------------------------------------------------------------------
// Every request gives exactly one response. The request register latches
// the request and forms the saturated insert time; the execute state lets
// every cell compare against it and shift in one pass, and the
// response is registered. A new request is taken the cycle after, while the
// response may still wait on rsp_stall; a waiting response holds back only
// the execute state of the following request. The cell row is
// min(NUM_ELEMENTS, 64) slots deep, and a cancel ripples a match flag along
// it. Reset empties the queue at once, with no clearing pass.
module timed_event_queue_unit #(
   parameter int NUM_ELEMENTS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  teq_pkg::teq_req_type        req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output teq_pkg::teq_rsp_type        rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [teq_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [teq_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [teq_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import teq_pkg::*;

   localparam int PEND_W = (NUM_ELEMENTS < ID_RANGE) ? NUM_ELEMENTS : ID_RANGE;
   localparam int IDX_W  = $clog2(PEND_W);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } teq_state_type;

   teq_state_type     state_ff, state_in;
   teq_req_type       req_ff;
   logic [TIME_W-1:0] t_ins_ff;
   logic [TIME_W-1:0] sim_time_ff, sim_time_in;
   logic [TIME_W-1:0] frame_end_ff, frame_end_in;
   logic [PEND_W-1:0] pending_ff, pending_in;
   logic              rsp_valid_ff, rsp_valid_in;
   teq_rsp_type       rsp_ff, rsp_in;

   teq_csr_type       csr_regs;
   teq_cell_ctrl_type cell_ctrl;
   teq_entry_type     ent   [PEND_W];
   logic              keep  [PEND_W];
   logic              hit   [PEND_W];

   logic              req_accept;
   logic              exec_fire;
   logic              id_ok;
   logic              is_pending;
   logic [IDX_W-1:0]  req_idx;
   logic [IDX_W-1:0]  head_idx;
   logic              head_due;

   teq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .csr_regs    (csr_regs)
   );

   generate
      for (genvar i = 0; i < PEND_W; i++) begin : g_cell
         teq_entry_type left_e;
         teq_entry_type right_e;
         logic          left_k;
         logic          hit_i;
         if (i == 0) begin : g_first
            assign left_e = '0;
            assign left_k = 1'b1;
            assign hit_i  = 1'b0;
         end else begin : g_mid
            assign left_e = ent[i-1];
            assign left_k = keep[i-1];
            assign hit_i  = hit[i-1];
         end
         if (i == PEND_W - 1) begin : g_last
            assign right_e = '0;
         end else begin : g_inner
            assign right_e = ent[i+1];
         end
         teq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (cell_ctrl),
            .left_entry  (left_e),
            .left_keep   (left_k),
            .right_entry (right_e),
            .hit_in      (hit_i),
            .entry       (ent[i]),
            .keep        (keep[i]),
            .hit_out     (hit[i])
         );
      end
   endgenerate

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign exec_fire  = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   assign id_ok      = (32'(req_ff.element_id) < NUM_ELEMENTS);
   assign req_idx    = req_ff.element_id[IDX_W-1:0];
   assign is_pending = id_ok && pending_ff[req_idx];
   assign head_idx   = ent[0].id[IDX_W-1:0];
   assign head_due   = ent[0].valid && (ent[0].stamp <= frame_end_ff);

   always_comb begin
      state_in     = state_ff;
      sim_time_in  = sim_time_ff;
      frame_end_in = frame_end_ff;
      pending_in   = pending_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cell_ctrl.op    = CELL_HOLD;
      cell_ctrl.id    = req_ff.element_id;
      cell_ctrl.stamp = t_ins_ff;

      if (req_accept) begin
         state_in = ST_EXEC;
      end

      if (exec_fire) begin
         state_in              = ST_IDLE;
         rsp_valid_in          = 1'b1;
         rsp_in.status         = STAT_DONE;
         rsp_in.popped_element = '0;
         rsp_in.event_time     = '0;
         case (req_ff.req_type)
            REQ_INSERT: begin
               if (!csr_regs.accept_events || !id_ok) begin
                  rsp_in.status = STAT_DISABLED;
               end else if (pending_ff[req_idx]) begin
                  rsp_in.status = STAT_PENDING;
               end else begin
                  cell_ctrl.op        = CELL_INSERT;
                  pending_in[req_idx] = 1'b1;
                  rsp_in.event_time   = t_ins_ff;
               end
            end
            REQ_CANCEL: begin
               if (!is_pending) begin
                  rsp_in.status = STAT_NOT_PENDING;
               end else begin
                  cell_ctrl.op        = CELL_REMOVE;
                  pending_in[req_idx] = 1'b0;
               end
            end
            REQ_FRAME: begin
               frame_end_in = sat_add(sim_time_ff, csr_regs.frame_span);
            end
            REQ_POP: begin
               if (head_due) begin
                  cell_ctrl.op          = CELL_SHIFT;
                  pending_in[head_idx]  = 1'b0;
                  rsp_in.popped_element = ent[0].id;
                  rsp_in.event_time     = ent[0].stamp;
                  if (ent[0].stamp > sim_time_ff) begin
                     sim_time_in = ent[0].stamp;
                  end
               end else begin
                  rsp_in.status = STAT_NONE_DUE;
                  if (frame_end_ff > sim_time_ff) begin
                     sim_time_in = frame_end_ff;
                  end
               end
            end
            REQ_CLEAR: begin
               cell_ctrl.op = CELL_CLEAR;
               pending_in   = '0;
               sim_time_in  = SIM_TIME_RESET;
            end
            default: begin
               rsp_in.status = STAT_DONE;
            end
         endcase
         rsp_in.current_time = sim_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sim_time_ff  <= SIM_TIME_RESET;
         frame_end_ff <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sim_time_ff  <= sim_time_in;
         frame_end_ff <= frame_end_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_accept) begin
         req_ff   <= req_data;
         t_ins_ff <= sat_add(sim_time_ff, req_data.delay);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_row_packed: assert property (@(posedge clock) disable iff (reset)
      ent[0].valid || !ent[1].valid)
      else $error("queue row has a gap at its head");

   a_row_sorted: assert property (@(posedge clock) disable iff (reset)
      (ent[0].valid && ent[1].valid) |-> (ent[0].stamp <= ent[1].stamp))
      else $error("queue head is later than its successor");

   a_head_pending: assert property (@(posedge clock) disable iff (reset)
      ent[0].valid |-> pending_ff[head_idx])
      else $error("queue head element is not marked pending");

   a_time_nonzero: assert property (@(posedge clock) disable iff (reset)
      sim_time_ff != '0)
      else $error("simulation time reached zero");

   a_fire_response: assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> (rsp_valid && (state_ff == ST_IDLE)))
      else $error("executed request did not produce a response");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timed event queue unit. A clocked driver sends
// insert, cancel, frame, pop and clear requests from a backlog; a clocked
// monitor compares every response, field by field, with an in-bench model
// of the queue. Both sides idle at random. Registers are set between phases.
// ----------------------------------------------------------------------------
module testbench;
   import teq_pkg::*;

   localparam int NUM_IDS = 64;
   localparam int CYCLE_LIMIT = 600000;
   localparam int REPORT_LIMIT = 10;
   localparam logic [ADDR_W-1:0] ADDR_ACCEPT = 4'd0;
   localparam logic [ADDR_W-1:0] ADDR_SPAN = 4'd8;
   localparam logic [TYPE_W-1:0] REQ_SPARE_FIRST = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_SPARE_LAST = 3'd7;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   teq_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   teq_rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0] csr_pwdata = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // queue model
   logic model_accept = 1'b0;
   logic [TIME_W-1:0] model_span = FRAME_SPAN_RESET;
   logic [TIME_W-1:0] model_now = SIM_TIME_RESET;
   logic [TIME_W-1:0] model_frame_end = '0;
   logic [TIME_W-1:0] model_stamp [NUM_IDS];
   logic [ELEM_W-1:0] model_order [$];

   teq_req_type request_backlog [$];
   teq_rsp_type queued_replies [$];
   teq_rsp_type want;
   int issued_count = 0;
   int taken_count = 0;
   int error_count = 0;
   int cycle_count = 0;
   int send_wait = 0;
   int send_calm = 0;
   int hold_left = 0;
   int hold_calm = 0;

   timed_event_queue_unit #(.NUM_ELEMENTS(NUM_IDS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [TIME_W-1:0] sum_saturated(input logic [TIME_W-1:0] a,
                                                       input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] s;
      s = a + b;
      return (s < a) ? TIME_MAX : s;
   endfunction

   function automatic teq_rsp_type advance_event_queue(input teq_req_type r);
      teq_rsp_type rsp;
      logic [TIME_W-1:0] stamp;
      logic [ELEM_W-1:0] el;
      int slot;
      rsp = '0;
      rsp.status = STAT_DONE;
      case (r.req_type)
         REQ_INSERT: begin
            if (!model_accept) begin
               rsp.status = STAT_DISABLED;
            end else if (model_stamp[r.element_id] != '0) begin
               rsp.status = STAT_PENDING;
            end else if (model_order.size() < NUM_IDS) begin
               stamp = sum_saturated(model_now, r.delay);
               slot = 0;
               while (slot < model_order.size() && model_stamp[model_order[slot]] < stamp)
                  slot++;
               model_order.insert(slot, r.element_id);
               model_stamp[r.element_id] = stamp;
               rsp.event_time = stamp;
            end
         end
         REQ_CANCEL: begin
            if (model_stamp[r.element_id] == '0) begin
               rsp.status = STAT_NOT_PENDING;
            end else begin
               for (slot = 0; slot < model_order.size(); slot++) begin
                  if (model_order[slot] == r.element_id) begin
                     model_order.delete(slot);
                     break;
                  end
               end
               model_stamp[r.element_id] = '0;
            end
         end
         REQ_FRAME: begin
            model_frame_end = sum_saturated(model_now, model_span);
         end
         REQ_POP: begin
            if (model_order.size() > 0 && model_stamp[model_order[0]] <= model_frame_end) begin
               el = model_order.pop_front();
               stamp = model_stamp[el];
               model_stamp[el] = '0;
               if (stamp > model_now) model_now = stamp;
               rsp.popped_element = el;
               rsp.event_time = stamp;
            end else begin
               rsp.status = STAT_NONE_DUE;
               if (model_frame_end > model_now) model_now = model_frame_end;
            end
         end
         REQ_CLEAR: begin
            foreach (model_stamp[k]) model_stamp[k] = '0;
            model_order.delete();
            model_now = SIM_TIME_RESET;
         end
         default: begin
         end
      endcase
      rsp.current_time = model_now;
      return rsp;
   endfunction

   function automatic void flag_mismatch(input string what, input logic [63:0] exp_val,
                                         input logic [63:0] act_val);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("MISMATCH %s: expected %0d, actual %0d at %0t",
                  what, exp_val, act_val, $realtime);
   endfunction

   function automatic teq_req_type make_req(input logic [TYPE_W-1:0] kind,
                                            input logic [ELEM_W-1:0] id,
                                            input logic [TIME_W-1:0] dly);
      teq_req_type r;
      r.req_type = kind;
      r.element_id = id;
      r.delay = dly;
      return r;
   endfunction

   function automatic logic [TIME_W-1:0] pick_delay();
      logic [TIME_W-1:0] d;
      case ($urandom_range(0, 19))
         0: d = '0;
         1: d = TIME_MAX;
         2: d = TIME_MAX - 64'($urandom_range(0, 1000));
         3, 4: d = {$urandom, $urandom};
         5: d = 64'd1 << $urandom_range(0, 63);
         6, 7: d = 64'($urandom_range(0, 8) * 250);
         default: d = 64'($urandom_range(0, 3000));
      endcase
      return d;
   endfunction

   function automatic teq_req_type random_request();
      int pick;
      logic [TYPE_W-1:0] kind;
      logic [ELEM_W-1:0] id;
      pick = $urandom_range(0, 99);
      if (pick < 40) kind = REQ_INSERT;
      else if (pick < 50) kind = REQ_CANCEL;
      else if (pick < 62) kind = REQ_FRAME;
      else if (pick < 94) kind = REQ_POP;
      else if (pick < 97) kind = REQ_CLEAR;
      else kind = TYPE_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
      id = ($urandom_range(0, 9) < 7) ? ELEM_W'($urandom_range(0, 15))
                                      : ELEM_W'($urandom_range(0, 63));
      return make_req(kind, id, pick_delay());
   endfunction

   task automatic queue_request(input teq_req_type r);
      request_backlog.push_back(r);
      issued_count++;
   endtask

   task automatic wait_idle();
      while (taken_count != issued_count || queued_replies.size() != 0)
         @(posedge clock);
   endtask

   // write through an APB transfer, then read the register back
   task automatic set_register(input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] value);
      logic [DATA_W-1:0] mask;
      mask = (addr == ADDR_ACCEPT) ? 64'd1 : '1;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == ADDR_ACCEPT) model_accept = value[0];
      else model_span = value;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if ((csr_prdata & mask) != (value & mask))
         flag_mismatch("register read", value & mask, csr_prdata & mask);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic run_phase(input logic accept, input logic [TIME_W-1:0] span,
                            input int count, input bit fill);
      wait_idle();
      set_register(ADDR_ACCEPT, {63'd0, accept});
      set_register(ADDR_SPAN, span);
      if (fill) begin
         queue_request(make_req(REQ_CLEAR, '0, '0));
         queue_request(make_req(REQ_FRAME, '0, '0));
         for (int k = 0; k < NUM_IDS; k++)
            queue_request(make_req(REQ_INSERT, ELEM_W'(k),
                                   TIME_W'($urandom_range(0, 4) * 50)));
         queue_request(make_req(REQ_INSERT, ELEM_W'($urandom_range(0, 63)), '0));
      end
      repeat (count) queue_request(random_request());
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            queued_replies.push_back(advance_event_queue(req_data));
            taken_count++;
         end
         if (!(req_valid && req_stall)) begin
            if (send_wait > 0) begin
               send_wait <= send_wait - 1;
               req_valid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
               req_data <= request_backlog.pop_front();
               req_valid <= 1'b1;
               if (send_calm > 0) send_calm--;
               else if ($urandom_range(0, 24) == 0) send_calm = $urandom_range(15, 50);
               send_wait <= (send_calm > 0) ? 0 : $urandom_range(0, 14);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (queued_replies.size() == 0) begin
               flag_mismatch("response with none expected", '0, rsp_data.current_time);
            end else begin
               want = queued_replies.pop_front();
               if (rsp_data.status !== want.status)
                  flag_mismatch("status", 64'(want.status), 64'(rsp_data.status));
               if (rsp_data.popped_element !== want.popped_element)
                  flag_mismatch("popped_element", 64'(want.popped_element),
                                64'(rsp_data.popped_element));
               if (rsp_data.event_time !== want.event_time)
                  flag_mismatch("event_time", want.event_time, rsp_data.event_time);
               if (rsp_data.current_time !== want.current_time)
                  flag_mismatch("current_time", want.current_time, rsp_data.current_time);
            end
            if (hold_calm > 0) hold_calm--;
            else if ($urandom_range(0, 24) == 0) hold_calm = $urandom_range(15, 50);
            hold_left = (hold_calm > 0) ? 0 : $urandom_range(0, 14);
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      foreach (model_stamp[k]) model_stamp[k] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: inserts rejected, default span
      queue_request(make_req(REQ_INSERT, 6'd3, 64'd10));
      queue_request(make_req(REQ_CANCEL, 6'd3, '0));
      queue_request(make_req(REQ_POP, '0, '0));
      queue_request(make_req(REQ_FRAME, '0, '0));
      queue_request(make_req(REQ_POP, '0, '0));
      queue_request(make_req(REQ_CLEAR, '0, '0));

      // ordering, ties, saturation, cancel, spare codes
      wait_idle();
      set_register(ADDR_ACCEPT, 64'd1);
      set_register(ADDR_SPAN, 64'd100);
      queue_request(make_req(REQ_INSERT, 6'd0, '0));
      queue_request(make_req(REQ_INSERT, 6'd63, TIME_MAX));
      queue_request(make_req(REQ_INSERT, 6'd63, 64'd5));
      queue_request(make_req(REQ_INSERT, 6'd10, 64'd20));
      queue_request(make_req(REQ_INSERT, 6'd11, 64'd20));
      queue_request(make_req(REQ_INSERT, 6'd12, 64'h8000_0000_0000_0000));
      queue_request(make_req(REQ_CANCEL, 6'd12, '0));
      queue_request(make_req(REQ_CANCEL, 6'd12, '0));
      queue_request(make_req(REQ_POP, '0, '0));
      queue_request(make_req(REQ_FRAME, '0, '0));
      queue_request(make_req(REQ_POP, '0, '0));
      queue_request(make_req(REQ_POP, '0, '0));
      queue_request(make_req(REQ_POP, '0, '0));
      for (int k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++)
         queue_request(make_req(TYPE_W'(k), 6'd63, TIME_MAX));

      // widest frame: saturated events become due, time pins at the top
      wait_idle();
      set_register(ADDR_SPAN, TIME_MAX);
      queue_request(make_req(REQ_FRAME, '0, '0));
      queue_request(make_req(REQ_POP, '0, '0));
      queue_request(make_req(REQ_INSERT, 6'd1, 64'd1));
      queue_request(make_req(REQ_POP, '0, '0));

      run_phase(1'b1, 64'd1, 150, 1'b0);
      run_phase(1'b1, 64'd1000, 300, 1'b0);
      run_phase(1'b0, 64'd5000, 60, 1'b0);
      run_phase(1'b1, FRAME_SPAN_RESET, 250, 1'b0);
      run_phase(1'b1, {$urandom, $urandom} | 64'd1, 150, 1'b0);
      run_phase(1'b1, TIME_MAX, 300, 1'b1);

      wait_idle();
      repeat (8) @(posedge clock);
      if (queued_replies.size() != 0)
         flag_mismatch("responses missing", '0, 64'(queued_replies.size()));
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
